>>> rtl/pps_pkg.sv
package pps_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W    = 14;
  localparam int ERR_W      = 15;
  localparam int DERR_W     = 16;
  localparam int DRIVE_W    = 16;
  localparam int SEP_BAND_W = 14;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SEP_BAND_W-1:0] SEP_BAND_RESET = 14'd180;

  // Output range of the drive
  localparam int DRIVE_MAX = 32767;
  localparam int DRIVE_MIN = -32768;

  // Scaling divisors for the two loop modes
  localparam int DIV_INC = 5;
  localparam int DIV_POS = 50;

  // Loop mode codes
  localparam logic MODE_INC = 1'b0;
  localparam logic MODE_POS = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP_MODE = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_SEP_BAND  = 3'd4
  } cfg_reg_t;

endpackage

>>> rtl/pps_divc.sv
module pps_divc #(
  parameter int WIDTH = 25
) (
  input  logic             mode_pos,
  input  logic [WIDTH-1:0] mag,
  output logic [WIDTH-1:0] quo
);
  import pps_pkg::*;

  localparam logic [WIDTH:0]   POW       = {1'b1, {WIDTH{1'b0}}};
  localparam logic [WIDTH-1:0] RECIP_INC = WIDTH'(POW / DIV_INC);
  localparam logic [WIDTH-1:0] RECIP_POS = WIDTH'(POW / DIV_POS);

  logic [2*WIDTH-1:0] prod;
  logic [WIDTH-1:0]   q0;
  logic [WIDTH-1:0]   back;
  logic [WIDTH-1:0]   rem;
  logic [WIDTH-1:0]   dvs;

  // Reciprocal estimate is low by at most one; fix it with one compare
  assign prod = (2*WIDTH)'(mag) * (2*WIDTH)'(mode_pos ? RECIP_POS : RECIP_INC);
  assign q0   = prod[2*WIDTH-1:WIDTH];
  assign dvs  = mode_pos ? WIDTH'(DIV_POS) : WIDTH'(DIV_INC);
  assign back = mode_pos ? WIDTH'(q0 * WIDTH'(DIV_POS)) : WIDTH'(q0 * WIDTH'(DIV_INC));
  assign rem  = mag - back;
  assign quo  = (rem >= dvs) ? q0 + WIDTH'(1) : q0;

endmodule

>>> rtl/pi_pd_speed_regulator_core.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_stall   | in_measured[13:0], in_target[13:0], in_clear
// out      | out_valid / out_stall | out_drive[15:0]
// cfg      | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data
//
// One transaction per cycle in and out while nothing stalls; out_valid follows
// input acceptance through the four-register pipeline: input, gain multiply,
// constant divide, accumulate/saturate into the output register.
// The drive accumulator is the only loop; it closes in the last stage.
// rst_n is synchronous, active low; it clears valids, config and state.
// out_stall holds the output register; earlier stages advance into bubbles,
// and in_stall rises only while all four stages hold.
module pi_pd_speed_regulator_core #(
  parameter int GAIN_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pps_pkg::FIELD_W-1:0]  in_measured,
  input  logic signed [pps_pkg::FIELD_W-1:0]  in_target,
  input  logic                                in_clear,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pps_pkg::DRIVE_W-1:0]  out_drive,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((GAIN_BITS > pps_pkg::SEP_BAND_W) ? GAIN_BITS
                 : pps_pkg::SEP_BAND_W)-1:0]  cfg_data
);
  import pps_pkg::*;

  // Product magnitude: 15-bit operand magnitude times gain
  localparam int MAG_W  = ERR_W + GAIN_BITS;
  localparam int TERM_W = MAG_W + 1;
  localparam int SUM_W  = MAG_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(DRIVE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(DRIVE_MIN);

  // ---------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------
  logic                  loop_mode_r;
  logic [GAIN_BITS-1:0]  gain_p_r;
  logic [GAIN_BITS-1:0]  gain_i_r;
  logic [GAIN_BITS-1:0]  gain_d_r;
  logic [SEP_BAND_W-1:0] sep_band_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r <= MODE_INC;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      sep_band_r  <= SEP_BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOOP_MODE: loop_mode_r <= cfg_data[0];
        REG_GAIN_P:    gain_p_r    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_I:    gain_i_r    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_D:    gain_d_r    <= cfg_data[GAIN_BITS-1:0];
        REG_SEP_BAND:  sep_band_r  <= cfg_data[SEP_BAND_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or drains
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !s3_valid_r || rdy_out;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    s1_valid_r  <= in_valid;
      if (rdy2)    s2_valid_r  <= s1_valid_r;
      if (rdy3)    s3_valid_r  <= s2_valid_r;
      if (rdy_out) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic signed [FIELD_W-1:0] s1_meas_r;
  logic signed [FIELD_W-1:0] s1_tgt_r;
  logic                      s1_clear_r;

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_meas_r  <= in_measured;
      s1_tgt_r   <= in_target;
      s1_clear_r <= in_clear;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: error, error delta, separation test and gain products.
  // The error history depends only on the inputs, so it advances here.
  // ---------------------------------------------------------------------
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic [DERR_W-1:0]        derr_abs;
  logic [ERR_W-1:0]         err_mag;
  logic [ERR_W-1:0]         derr_mag;
  logic                     in_band;
  logic                     mode_pos;
  logic [ERR_W-1:0]         a_mag, b_mag;
  logic                     a_neg, b_neg;
  logic [GAIN_BITS-1:0]     b_gain;
  logic [MAG_W-1:0]         prod_a, prod_b;

  assign mode_pos = (loop_mode_r == MODE_POS);

  always_comb begin
    err      = ERR_W'(s1_tgt_r) - ERR_W'(s1_meas_r);
    derr     = DERR_W'(err) - DERR_W'(prev_err_r);
    err_mag  = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;
    derr_abs = derr[DERR_W-1] ? (~derr + DERR_W'(1)) : derr;
    derr_mag = derr_abs[ERR_W-1:0];
    // integral separation: the I term acts only inside the band
    in_band  = (err_mag <= ERR_W'(sep_band_r));

    if (mode_pos) begin
      a_mag  = err_mag;
      a_neg  = err[ERR_W-1];
      b_gain = gain_d_r;
      b_mag  = derr_mag;
      b_neg  = derr[DERR_W-1];
    end else begin
      a_mag  = derr_mag;
      a_neg  = derr[DERR_W-1];
      b_gain = gain_i_r;
      b_mag  = in_band ? err_mag : '0;
      b_neg  = in_band && err[ERR_W-1];
    end

    prod_a = MAG_W'(a_mag) * MAG_W'(gain_p_r);
    prod_b = MAG_W'(b_mag) * MAG_W'(b_gain);
  end

  logic [MAG_W-1:0] s2_prod_a_r, s2_prod_b_r;
  logic             s2_neg_a_r, s2_neg_b_r, s2_clear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (s1_valid_r && rdy2) begin
      prev_err_r <= s1_clear_r ? '0 : err;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_prod_a_r <= prod_a;
      s2_prod_b_r <= prod_b;
      s2_neg_a_r  <= a_neg;
      s2_neg_b_r  <= b_neg;
      s2_clear_r  <= s1_clear_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: divide magnitudes by 5 or 50 (truncation toward zero)
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0] quo_a, quo_b;

  pps_divc #(.WIDTH(MAG_W)) u_div_a (
    .mode_pos (mode_pos),
    .mag      (s2_prod_a_r),
    .quo      (quo_a)
  );

  pps_divc #(.WIDTH(MAG_W)) u_div_b (
    .mode_pos (mode_pos),
    .mag      (s2_prod_b_r),
    .quo      (quo_b)
  );

  logic [MAG_W-1:0] s3_quo_a_r, s3_quo_b_r;
  logic             s3_neg_a_r, s3_neg_b_r, s3_clear_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_quo_a_r <= quo_a;
      s3_quo_b_r <= quo_b;
      s3_neg_a_r <= s2_neg_a_r;
      s3_neg_b_r <= s2_neg_b_r;
      s3_clear_r <= s2_clear_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sign, sum, saturate and update the drive accumulator.
  // The output register doubles as the accumulator.
  // ---------------------------------------------------------------------
  logic signed [DRIVE_W-1:0] drive_acc_r;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic signed [TERM_W-1:0]  term_a, term_b;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DRIVE_W-1:0] sum_sat;
  logic signed [DRIVE_W:0]   acc;
  logic signed [DRIVE_W-1:0] acc_sat;

  always_comb begin
    term_a = s3_neg_a_r ? -$signed({1'b0, s3_quo_a_r}) : $signed({1'b0, s3_quo_a_r});
    term_b = s3_neg_b_r ? -$signed({1'b0, s3_quo_b_r}) : $signed({1'b0, s3_quo_b_r});
    sum    = SUM_W'(term_a) + SUM_W'(term_b);

    if (sum > SUM_MAX) begin
      sum_sat = DRIVE_W'(DRIVE_MAX);
    end else if (sum < SUM_MIN) begin
      sum_sat = DRIVE_W'(DRIVE_MIN);
    end else begin
      sum_sat = DRIVE_W'(sum);
    end

    // incremental mode: saturated increment, then saturated accumulate
    acc = (DRIVE_W+1)'(drive_acc_r) + (DRIVE_W+1)'(sum_sat);
    if (acc[DRIVE_W] != acc[DRIVE_W-1]) begin
      acc_sat = acc[DRIVE_W] ? DRIVE_W'(DRIVE_MIN) : DRIVE_W'(DRIVE_MAX);
    end else begin
      acc_sat = acc[DRIVE_W-1:0];
    end

    if (s3_clear_r) begin
      drive_nxt = '0;
    end else if (mode_pos) begin
      drive_nxt = sum_sat;
    end else begin
      drive_nxt = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_acc_r <= '0;
    end else if (s3_valid_r && rdy_out) begin
      drive_acc_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = drive_acc_r;

endmodule

>>> rtl/pps_checker.sv
module pps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_clear,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_drive
);

  // Hold the result while the output is stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive))
    else $error("stalled output changed");

  // Input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Nothing valid right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A clear flows through an unstalled pipeline and shows a zero drive
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_clear) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid && (out_drive == 16'sd0))
    else $error("clear did not produce zero drive");

endmodule

bind pi_pd_speed_regulator_core pps_checker u_pps_checker (.*);

>>> verif/tb_pi_pd_speed_regulator_core.sv
`timescale 1ns / 1ps

module tb_pi_pd_speed_regulator_core;
  import pps_pkg::*;

  localparam int GAIN_BITS     = 10;
  localparam int CFG_W         = (GAIN_BITS > SEP_BAND_W) ? GAIN_BITS : SEP_BAND_W;
  localparam int GAIN_MASK     = (1 << GAIN_BITS) - 1;
  localparam int GAIN_TOP      = GAIN_MASK;
  localparam int FIELD_MAX     = (1 << (FIELD_W - 1)) - 1;
  localparam int FIELD_MIN     = -(1 << (FIELD_W - 1));
  localparam int SEP_BAND_TOP  = (1 << SEP_BAND_W) - 1;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 90;
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 300000;

  // Indexes past the last register; writes there must leave the block alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [FIELD_W-1:0] meas;
    logic signed [FIELD_W-1:0] tgt;
    logic                      clr;
  } sample_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
  } reg_write_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  // DUT inputs start at known values
  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic signed [FIELD_W-1:0]   in_measured = '0;
  logic signed [FIELD_W-1:0]   in_target   = '0;
  logic                        in_clear    = 1'b0;
  logic                        out_stall   = 1'b0;
  logic                        cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index   = '0;
  logic [CFG_W-1:0]            cfg_data    = '0;
  logic                        in_stall;
  logic                        out_valid;
  logic signed [DRIVE_W-1:0]   out_drive;
  logic                        cfg_ready;

  // Shadow of the register file, updated at each config handshake
  logic mode_cfg = MODE_INC;
  int   kp_cfg   = 0;
  int   ki_cfg   = 0;
  int   kd_cfg   = 0;
  int   sep_cfg  = int'(SEP_BAND_RESET);

  // Shadow of the loop state
  int last_error = 0;
  int drive_acc  = 0;

  sample_t                   pending_samples[$];
  logic signed [DRIVE_W-1:0] expected_drive[$];
  reg_write_t                reg_batch[$];
  sample_t                   next_sample;

  int samples_queued = 0;
  int samples_sent   = 0;
  int clears_sent    = 0;
  int drive_checks   = 0;
  int reg_writes     = 0;
  int settings_seen  = 0;
  int err_count      = 0;
  int cycle_count    = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  int hold_left      = 0;
  int style_left     = 0;
  int setpoint       = 0;
  stall_style_t stall_style = STALL_NONE;

  pi_pd_speed_regulator_core #(
    .GAIN_BITS(GAIN_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_measured(in_measured),
    .in_target  (in_target),
    .in_clear   (in_clear),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_drive  (out_drive),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp16(input int v);
    if (v > DRIVE_MAX) return DRIVE_MAX;
    if (v < DRIVE_MIN) return DRIVE_MIN;
    return v;
  endfunction

  // Advance the shadow loop by one control step and return the new drive.
  // Integer division in SV truncates toward zero, as the loop requires.
  function automatic logic signed [DRIVE_W-1:0] regulate_step(
    input logic signed [FIELD_W-1:0] meas, tgt,
    input logic                      clr
  );
    int err;
    int derr;
    int mag;
    int band_err;
    int incr;
    if (clr) begin
      last_error = 0;
      drive_acc  = 0;
    end else begin
      err  = int'(tgt) - int'(meas);
      derr = err - last_error;
      if (mode_cfg == MODE_INC) begin
        // Integral separation: the integral term only acts inside the band
        mag      = (err < 0) ? -err : err;
        band_err = (mag <= sep_cfg) ? err : 0;
        incr     = clamp16((kp_cfg * derr) / DIV_INC + (ki_cfg * band_err) / DIV_INC);
        drive_acc = clamp16(drive_acc + incr);
      end else begin
        drive_acc = clamp16((kp_cfg * err) / DIV_POS + (kd_cfg * derr) / DIV_POS);
      end
      last_error = err;
    end
    return DRIVE_W'(drive_acc);
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic queue_sample(input int meas, input int tgt, input bit clr);
    sample_t s;
    s.meas = FIELD_W'(meas);
    s.tgt  = FIELD_W'(tgt);
    s.clr  = clr;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // Hold until every queued sample went in and every drive came back
  task automatic drain();
    @(posedge clk);
    while (samples_sent != samples_queued || expected_drive.size() != 0) @(posedge clk);
  endtask

  // Write the batch back to back, keeping cfg_valid high between writes.
  // Call only at a rising edge with the block idle.
  task automatic apply_reg_batch();
    reg_write_t w;
    while (reg_batch.size() != 0) begin
      w = reg_batch.pop_front();
      cfg_index <= w.idx;
      cfg_data  <= w.value;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (w.idx)
        REG_LOOP_MODE: mode_cfg = w.value[0];
        REG_GAIN_P:    kp_cfg   = int'(w.value) & GAIN_MASK;
        REG_GAIN_I:    ki_cfg   = int'(w.value) & GAIN_MASK;
        REG_GAIN_D:    kd_cfg   = int'(w.value) & GAIN_MASK;
        REG_SEP_BAND:  sep_cfg  = int'(w.value);
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    reg_write_t w;
    w.idx   = idx;
    w.value = CFG_W'(value);
    reg_batch.push_back(w);
  endtask

  // Gains: zero, full scale, or random raw data with the ignored upper bits set at random
  function automatic int pick_gain();
    int pick;
    pick = $urandom_range(3, 0);
    if (pick == 0) return 0;
    if (pick == 1) return GAIN_TOP;
    return $urandom_range(SEP_BAND_TOP, 0);
  endfunction

  function automatic int pick_extreme();
    int pick;
    pick = $urandom_range(3, 0);
    if (pick == 0) return FIELD_MIN;
    if (pick == 1) return FIELD_MAX;
    if (pick == 2) return 0;
    return -1;
  endfunction

  // Mostly a regulated loop: the speed hovers around a setpoint that jumps now and then.
  // The rest is clears, field extremes and raw noise over the full field range.
  task automatic queue_random_sample();
    int kind;
    int meas;
    kind = $urandom_range(99, 0);
    if ($urandom_range(19, 0) == 0) setpoint = $urandom_range(FIELD_MAX - FIELD_MIN, 0) + FIELD_MIN;
    if (kind < 5) begin
      queue_sample($urandom_range(FIELD_MAX - FIELD_MIN, 0) + FIELD_MIN, setpoint, 1'b1);
    end else if (kind < 65) begin
      meas = setpoint + $urandom_range(400, 0) - 200;
      if (meas > FIELD_MAX) meas = FIELD_MAX;
      if (meas < FIELD_MIN) meas = FIELD_MIN;
      queue_sample(meas, setpoint, 1'b0);
    end else if (kind < 75) begin
      queue_sample(pick_extreme(), pick_extreme(), 1'b0);
    end else begin
      queue_sample($urandom_range(FIELD_MAX - FIELD_MIN, 0) + FIELD_MIN,
                   $urandom_range(FIELD_MAX - FIELD_MIN, 0) + FIELD_MIN, 1'b0);
    end
  endtask

  // Driver: offer samples in bursts of random length with random gaps.
  // A stalled transaction holds its payload; prediction happens on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_drive.push_back(regulate_step(in_measured, in_target, in_clear));
        samples_sent++;
        if (in_clear) clears_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_sample = pending_samples.pop_front();
          in_measured <= next_sample.meas;
          in_target   <= next_sample.tgt;
          in_clear    <= next_sample.clr;
          in_valid    <= 1'b1;
          // Close the burst and draw the gap; a quarter of the bursts run straight on
          if (burst_left <= 1) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern: a style per stretch, plus long holds on request
  // so that the pipeline backs up into in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = $urandom_range(150, 100);
      end
      if (style_left == 0) begin
        stall_style = stall_style_t'($urandom_range(3, 0));
        style_left  = $urandom_range(80, 20);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(9, 0) < 7);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Monitor: compare each accepted drive with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        note_failure($sformatf("drive %0d with no transaction pending", out_drive));
      end else begin
        drive_checks++;
        if (out_drive !== expected_drive[0]) begin
          note_failure($sformatf("drive #%0d: expected %0d, got %0d",
                                 drive_checks, expected_drive[0], out_drive));
        end
        void'(expected_drive.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ERROR: cycle limit reached with %0d samples and %0d drives outstanding",
               samples_queued - samples_sent, expected_drive.size());
      $display("tb_pi_pd_speed_regulator_core: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: all gains zero, so the drive must stay at zero
    queue_sample(100, -200, 1'b0);
    queue_sample(FIELD_MIN, FIELD_MAX, 1'b0);
    drain();

    // Incremental PI at full gain; upper data bits set to check they are dropped.
    // Leave the band at its reset value.
    push_reg(REG_GAIN_P, SEP_BAND_TOP);
    push_reg(REG_GAIN_I, SEP_BAND_TOP);
    apply_reg_batch();
    queue_sample(0, 180, 1'b0);              // error right on the band edge
    queue_sample(0, -180, 1'b0);             // negative band edge
    queue_sample(0, 181, 1'b0);              // just outside: integral drops out
    queue_sample(FIELD_MAX, FIELD_MIN, 1'b0); // most negative error, increment saturates
    queue_sample(FIELD_MIN, FIELD_MAX, 1'b0); // full swing the other way
    queue_sample(FIELD_MIN, FIELD_MAX, 1'b0); // no change in error, accumulator holds
    queue_sample(7, 0, 1'b0);
    queue_sample(FIELD_MIN, FIELD_MAX, 1'b1); // clear zeroes state and drive
    queue_sample(0, 3, 1'b0);                // truncation of both terms
    drain();

    // Positional PD at full gain
    push_reg(REG_LOOP_MODE, int'(MODE_POS));
    push_reg(REG_GAIN_D, GAIN_TOP);
    apply_reg_batch();
    queue_sample(FIELD_MIN, FIELD_MAX, 1'b0);
    queue_sample(FIELD_MAX, FIELD_MIN, 1'b0);
    queue_sample(7, 0, 1'b0);
    queue_sample(0, 1, 1'b0);
    queue_sample(0, -1, 1'b0);
    queue_sample(3, 3, 1'b1);
    queue_sample(FIELD_MAX, FIELD_MAX, 1'b0);
    drain();

    // Random phases: new settings each time, both modes, band extremes included
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      push_reg(REG_LOOP_MODE, (p % 2 == 0) ? int'(MODE_INC) : int'(MODE_POS));
      push_reg(REG_GAIN_P, pick_gain());
      push_reg(REG_GAIN_I, pick_gain());
      push_reg(REG_GAIN_D, pick_gain());
      if (p == 1)      push_reg(REG_SEP_BAND, 0);
      else if (p == 3) push_reg(REG_SEP_BAND, SEP_BAND_TOP);
      else if (p % 2 == 0) push_reg(REG_SEP_BAND, $urandom_range(400, 0));
      else             push_reg(REG_SEP_BAND, $urandom_range(SEP_BAND_TOP, 0));
      if ($urandom_range(1, 0) == 1)
        push_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                 $urandom_range(SEP_BAND_TOP, 0));
      apply_reg_batch();
      setpoint = $urandom_range(FIELD_MAX - FIELD_MIN, 0) + FIELD_MIN;
      // Back up the pipeline with a long output hold while samples keep coming
      if (p == 2 || p == 5) hold_requests++;
      for (int i = 0; i < PHASE_SAMPLES; i++) queue_random_sample();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples (%0d clears) and checked %0d drive values,",
             samples_sent, clears_sent, drive_checks);
    $display("over %0d settings from %0d register writes, with %0d long output holds.",
             settings_seen, reg_writes, holds_done);
    if (err_count == 0 && expected_drive.size() == 0) begin
      $display("tb_pi_pd_speed_regulator_core: PASS");
    end else begin
      $display("%0d mismatches, %0d drives missing", err_count, expected_drive.size());
      $display("tb_pi_pd_speed_regulator_core: FAIL");
    end
    $finish;
  end

endmodule
